// ===== rtl/core/ntc_tfd_pkg.sv =====
// ----------------------------------------------------------------------------
// ntc_tfd_pkg
// Shared constants, types and lookup functions of the NTC fan duty pipeline.
// ----------------------------------------------------------------------------
package ntc_tfd_pkg;

    localparam int ADC_BITS_DEF = 12;
    localparam int MV_W         = 12;
    localparam int CURVE_W      = 2;
    localparam int DUTY_W       = 11;
    localparam int KQ_W         = 41;
    localparam int INV_W        = 32;
    localparam int PADDR_W      = 3;

    localparam logic [63:0] NUM_Q8       = 64'd2816000000;
    localparam int          OFFSET_Q8    = 563200;
    localparam int          LOG2_10K_Q16 = 870824;
    localparam int          INV_T25_Q32  = 14405391;
    localparam int          LN2_B_Q32    = 746903;
    localparam int          KELVIN_Q8    = 69926;
    localparam int          DUTY_MAX     = 1200;
    localparam int          SUPPLY_RST   = 3300;

    localparam logic REG_SUPPLY = 1'b0;
    localparam logic REG_CURVE  = 1'b1;

    localparam logic [CURVE_W-1:0] CURVE_LAST = 2'd2;

    typedef struct packed {
        logic [CURVE_W-1:0] mode;
        logic               zero;
        logic               sat;
    } ctl_t;

    function automatic logic [16:0] log2_tab(input logic [4:0] j);
        logic [16:0] v;
        case (j)
            5'd0:    v = 17'd0;
            5'd1:    v = 17'd5732;
            5'd2:    v = 17'd11136;
            5'd3:    v = 17'd16248;
            5'd4:    v = 17'd21098;
            5'd5:    v = 17'd25711;
            5'd6:    v = 17'd30109;
            5'd7:    v = 17'd34312;
            5'd8:    v = 17'd38336;
            5'd9:    v = 17'd42196;
            5'd10:   v = 17'd45904;
            5'd11:   v = 17'd49472;
            5'd12:   v = 17'd52911;
            5'd13:   v = 17'd56229;
            5'd14:   v = 17'd59434;
            5'd15:   v = 17'd62534;
            default: v = 17'd65536;
        endcase
        return v;
    endfunction

    function automatic int curve_lo(input logic [CURVE_W-1:0] m);
        int v;
        case (m)
            2'd0:    v = 55;
            2'd1:    v = 50;
            default: v = 45;
        endcase
        return v;
    endfunction

    function automatic int curve_hi(input logic [CURVE_W-1:0] m);
        int v;
        case (m)
            2'd0:    v = 90;
            2'd1:    v = 80;
            default: v = 70;
        endcase
        return v;
    endfunction

    function automatic int curve_k(input logic [CURVE_W-1:0] m);
        int v;
        case (m)
            2'd0:    v = 15;
            2'd1:    v = 20;
            default: v = 22;
        endcase
        return v;
    endfunction

    function automatic int curve_b(input logic [CURVE_W-1:0] m);
        int v;
        case (m)
            2'd0:    v = -350;
            default: v = -400;
        endcase
        return v;
    endfunction

endpackage

// ===== rtl/core/ntc_temperature_fan_duty_top.sv =====
// ----------------------------------------------------------------------------
// ntc_temperature_fan_duty_top
// NTC divider reading to fan PWM compare value over a beta-equation curve.
// ----------------------------------------------------------------------------
// Usage:
//   Input channel adc_valid/adc_stall/adc_code carries one converter reading
//   per transaction; output channel duty_valid/duty_stall/duty_count returns
//   exactly one PWM compare value per reading, in order.
//   Throughput is one transaction per cycle while no result waits under
//   duty_stall. The pipeline is built from the two bit-per-stage dividers
//   (resistance, QW stages; kelvin, 41 stages), the NSH-stage normalizer
//   of the log2 unit and eight arithmetic stages, with QW the bit width of
//   2816000000*(2^ADC_BITS-1) and NSH = clog2(QW).
//   The pipeline moves as a whole: while a result waits under duty_stall
//   every stage holds and adc_stall is raised in the same cycle; no
//   transaction is lost or repeated. Reset clears all valid bits and loads
//   supply_millivolts = 3300 and curve_mode = 0. The user is to write the
//   APB port (byte address 0: supply, 4: curve) only while the pipeline
//   holds no transaction; the block itself does not enforce this.
// ----------------------------------------------------------------------------
module ntc_temperature_fan_duty_top
    import ntc_tfd_pkg::*;
#(
    parameter int ADC_BITS = ADC_BITS_DEF
)
(
    input  logic                clk,
    input  logic                rst_n,
    input  logic                psel,
    input  logic                penable,
    input  logic                pwrite,
    input  logic [PADDR_W-1:0]  paddr,
    input  logic [31:0]         pwdata,
    output logic [31:0]         prdata,
    output logic                pready,
    input  logic                adc_valid,
    output logic                adc_stall,
    input  logic [ADC_BITS-1:0] adc_code,
    output logic                duty_valid,
    input  logic                duty_stall,
    output logic [DUTY_W-1:0]   duty_count
);

    localparam logic [63:0] FULL     = (64'd1 << ADC_BITS) - 64'd1;
    localparam logic [63:0] DIVIDEND = NUM_Q8 * FULL;
    localparam int          QW       = $clog2(DIVIDEND + 64'd1);
    localparam int          PW       = ADC_BITS + MV_W;
    localparam int          NSH      = $clog2(QW);
    localparam int          E0       = QW - 9;
    localparam int          CW       = $bits(ctl_t);

    logic               en;
    logic               wr_en;
    logic [MV_W-1:0]    supply_reg;
    logic [CURVE_W-1:0] curve_reg;

    assign pready = 1'b1;
    assign wr_en  = psel && penable && pwrite && pready;
    assign prdata = (paddr[2] == REG_CURVE) ? {{(32-CURVE_W){1'b0}}, curve_reg}
                                            : {{(32-MV_W){1'b0}}, supply_reg};

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            supply_reg <= MV_W'(SUPPLY_RST);
            curve_reg  <= '0;
        end
        else if (wr_en)
        begin
            if (paddr[2] == REG_SUPPLY)
            begin
                supply_reg <= pwdata[MV_W-1:0];
            end
            else
            begin
                curve_reg <= pwdata[CURVE_W-1:0];
            end
        end
    end

    assign en        = !(duty_valid && duty_stall);
    assign adc_stall = !en;

    // stage 1: code times supply
    logic          s1_valid_reg;
    logic [PW-1:0] s1_prod_reg;
    ctl_t          s1_ctl_reg;
    ctl_t          s1_ctl_next;

    always_comb
    begin
        s1_ctl_next.mode = (curve_reg > CURVE_LAST) ? CURVE_LAST : curve_reg;
        s1_ctl_next.zero = (adc_code == '0) || (supply_reg == '0);
        s1_ctl_next.sat  = 1'b0;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg <= 1'b0;
        end
        else if (en)
        begin
            s1_valid_reg <= adc_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            s1_prod_reg <= PW'(adc_code) * PW'(supply_reg);
            s1_ctl_reg  <= s1_ctl_next;
        end
    end

    // resistance divider
    logic          d1_valid;
    logic [QW-1:0] d1_q;
    logic [CW-1:0] d1_side;

    ntc_tfd_div #(
        .NW (QW),
        .DW (PW),
        .SW (CW)
    ) u_div_res (
        .clk       (clk),
        .rst_n     (rst_n),
        .en        (en),
        .in_valid  (s1_valid_reg),
        .dividend  (DIVIDEND[QW-1:0]),
        .divisor   (s1_prod_reg),
        .side      (s1_ctl_reg),
        .out_valid (d1_valid),
        .quotient  (d1_q),
        .side_out  (d1_side)
    );

    // stage 2: remove series offset
    logic          s2_valid_reg;
    logic [QW-1:0] s2_r_reg;
    ctl_t          s2_ctl_reg;
    ctl_t          s2_ctl_next;

    always_comb
    begin
        s2_ctl_next     = ctl_t'(d1_side);
        s2_ctl_next.sat = d1_q <= QW'(OFFSET_Q8);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s2_valid_reg <= 1'b0;
        end
        else if (en)
        begin
            s2_valid_reg <= d1_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            s2_r_reg   <= d1_q - QW'(OFFSET_Q8);
            s2_ctl_reg <= s2_ctl_next;
        end
    end

    // normalizer: one binary shift step per stage
    logic           nm_valid_reg [0:NSH-1];
    logic [QW-1:0]  nm_x_reg     [0:NSH-1];
    logic [NSH-1:0] nm_lz_reg    [0:NSH-1];
    ctl_t           nm_ctl_reg   [0:NSH-1];

    genvar k;
    generate
        for (k = 0; k < NSH; k++)
        begin : g_norm
            localparam int S = 1 << (NSH - 1 - k);
            logic           v_src;
            logic [QW-1:0]  x_src;
            logic [NSH-1:0] lz_src;
            ctl_t           ctl_src;
            logic           hit;

            if (k == 0)
            begin : g_head
                assign v_src   = s2_valid_reg;
                assign x_src   = s2_r_reg;
                assign lz_src  = '0;
                assign ctl_src = s2_ctl_reg;
            end
            else
            begin : g_body
                assign v_src   = nm_valid_reg[k-1];
                assign x_src   = nm_x_reg[k-1];
                assign lz_src  = nm_lz_reg[k-1];
                assign ctl_src = nm_ctl_reg[k-1];
            end

            assign hit = (x_src[QW-1 -: S] == '0);

            always_ff @(posedge clk or negedge rst_n)
            begin
                if (!rst_n)
                begin
                    nm_valid_reg[k] <= 1'b0;
                end
                else if (en)
                begin
                    nm_valid_reg[k] <= v_src;
                end
            end

            always_ff @(posedge clk)
            begin
                if (en)
                begin
                    nm_x_reg[k]   <= hit ? (x_src << S) : x_src;
                    nm_lz_reg[k]  <= hit ? (lz_src + NSH'(S)) : lz_src;
                    nm_ctl_reg[k] <= ctl_src;
                end
            end
        end
    endgenerate

    // log2 stage 1: table lookup and interpolation product
    logic              l1_valid_reg;
    logic [38:0]       l1_prod_reg;
    logic [16:0]       l1_t0_reg;
    logic signed [7:0] l1_e_reg;
    ctl_t              l1_ctl_reg;
    logic [3:0]        lt_idx;
    logic [25:0]       lt_rem;
    logic [16:0]       lt_t0;
    logic [16:0]       lt_t1;
    logic [12:0]       lt_d;

    assign lt_idx = nm_x_reg[NSH-1][QW-2 -: 4];
    assign lt_rem = nm_x_reg[NSH-1][QW-6 -: 26];
    assign lt_t0  = log2_tab({1'b0, lt_idx});
    assign lt_t1  = log2_tab(5'({1'b0, lt_idx}) + 5'd1);
    assign lt_d   = 13'(lt_t1 - lt_t0);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            l1_valid_reg <= 1'b0;
        end
        else if (en)
        begin
            l1_valid_reg <= nm_valid_reg[NSH-1];
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            l1_prod_reg <= 39'(lt_d) * 39'(lt_rem);
            l1_t0_reg   <= lt_t0;
            l1_e_reg    <= 8'(E0) - 8'(nm_lz_reg[NSH-1]);
            l1_ctl_reg  <= nm_ctl_reg[NSH-1];
        end
    end

    // log2 stage 2: assemble log2(R) minus log2(10k)
    logic               l2_valid_reg;
    logic signed [25:0] l2_x_reg;
    ctl_t               l2_ctl_reg;
    logic [25:0]        l2_x_next;

    assign l2_x_next = {{2{l1_e_reg[7]}}, l1_e_reg, 16'b0} + 26'(l1_t0_reg)
                     + 26'(l1_prod_reg[38:26]) - 26'(LOG2_10K_Q16);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            l2_valid_reg <= 1'b0;
        end
        else if (en)
        begin
            l2_valid_reg <= l1_valid_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            l2_x_reg   <= $signed(l2_x_next);
            l2_ctl_reg <= l1_ctl_reg;
        end
    end

    // scale by ln2 / B
    logic               l3_valid_reg;
    logic signed [46:0] l3_m_reg;
    ctl_t               l3_ctl_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            l3_valid_reg <= 1'b0;
        end
        else if (en)
        begin
            l3_valid_reg <= l2_valid_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            l3_m_reg   <= 47'(l2_x_reg) * 47'sd746903;
            l3_ctl_reg <= l2_ctl_reg;
        end
    end

    // inverse temperature
    logic               l4_valid_reg;
    logic [INV_W-1:0]   l4_inv_reg;
    ctl_t               l4_ctl_reg;
    ctl_t               l4_ctl_next;
    logic signed [46:0] l4_madj;
    logic signed [32:0] l4_inv_next;

    assign l4_madj     = l3_m_reg + (l3_m_reg[46] ? 47'sd65535 : 47'sd0);
    assign l4_inv_next = 33'sd14405391 + 33'($signed(l4_madj[46:16]));

    always_comb
    begin
        l4_ctl_next     = l3_ctl_reg;
        l4_ctl_next.sat = l3_ctl_reg.sat || l4_inv_next[32] || (l4_inv_next == '0);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            l4_valid_reg <= 1'b0;
        end
        else if (en)
        begin
            l4_valid_reg <= l3_valid_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            l4_inv_reg <= l4_inv_next[INV_W-1:0];
            l4_ctl_reg <= l4_ctl_next;
        end
    end

    // kelvin divider
    logic            d2_valid;
    logic [KQ_W-1:0] d2_q;
    logic [CW-1:0]   d2_side;

    ntc_tfd_div #(
        .NW (KQ_W),
        .DW (INV_W),
        .SW (CW)
    ) u_div_kel (
        .clk       (clk),
        .rst_n     (rst_n),
        .en        (en),
        .in_valid  (l4_valid_reg),
        .dividend  (KQ_W'(1) << (KQ_W - 1)),
        .divisor   (l4_inv_reg),
        .side      (l4_ctl_reg),
        .out_valid (d2_valid),
        .quotient  (d2_q),
        .side_out  (d2_side)
    );

    // celsius, saturated to signed Q8.8
    logic                  tc_valid_reg;
    logic signed [15:0]    tc_reg;
    ctl_t                  tc_ctl_reg;
    logic signed [KQ_W:0]  tc_wide;
    logic signed [15:0]    tc_next;

    assign tc_wide = $signed({1'b0, d2_q}) - (KQ_W+1)'(KELVIN_Q8);

    always_comb
    begin
        if (tc_wide > (KQ_W+1)'(32767))
        begin
            tc_next = 16'sd32767;
        end
        else if (tc_wide < -(KQ_W+1)'(32768))
        begin
            tc_next = -16'sd32768;
        end
        else
        begin
            tc_next = tc_wide[15:0];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            tc_valid_reg <= 1'b0;
        end
        else if (en)
        begin
            tc_valid_reg <= d2_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            tc_reg     <= tc_next;
            tc_ctl_reg <= ctl_t'(d2_side);
        end
    end

    // fan curve and output register
    logic                 duty_valid_reg;
    logic [DUTY_W-1:0]    duty_count_reg;
    logic [DUTY_W-1:0]    duty_next;
    logic [DUTY_W-1:0]    floor_duty;
    logic signed [23:0]   lin;
    logic signed [23:0]   lin_adj;

    assign floor_duty = DUTY_W'(curve_k(tc_ctl_reg.mode) * curve_lo(tc_ctl_reg.mode)
                                + curve_b(tc_ctl_reg.mode));
    assign lin        = 24'(tc_reg) * 24'(curve_k(tc_ctl_reg.mode))
                      + 24'(curve_b(tc_ctl_reg.mode) * 256);
    assign lin_adj    = lin + (lin[23] ? 24'sd255 : 24'sd0);

    always_comb
    begin
        if (tc_ctl_reg.zero)
        begin
            duty_next = floor_duty;
        end
        else if (tc_ctl_reg.sat)
        begin
            duty_next = DUTY_W'(DUTY_MAX);
        end
        else if (int'(tc_reg) < curve_lo(tc_ctl_reg.mode) * 256)
        begin
            duty_next = floor_duty;
        end
        else if (int'(tc_reg) > curve_hi(tc_ctl_reg.mode) * 256)
        begin
            duty_next = DUTY_W'(DUTY_MAX);
        end
        else
        begin
            duty_next = lin_adj[DUTY_W+7:8];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            duty_valid_reg <= 1'b0;
        end
        else if (en)
        begin
            duty_valid_reg <= tc_valid_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            duty_count_reg <= duty_next;
        end
    end

    assign duty_valid = duty_valid_reg;
    assign duty_count = duty_count_reg;

endmodule

// ===== rtl/core/ntc_tfd_div.sv =====
// ----------------------------------------------------------------------------
// ntc_tfd_div
// Pipelined restoring divider, one quotient bit per stage, with sideband.
// ----------------------------------------------------------------------------
module ntc_tfd_div
    import ntc_tfd_pkg::*;
#(
    parameter int NW = KQ_W,
    parameter int DW = INV_W,
    parameter int SW = $bits(ctl_t)
)
(
    input  logic          clk,
    input  logic          rst_n,
    input  logic          en,
    input  logic          in_valid,
    input  logic [NW-1:0] dividend,
    input  logic [DW-1:0] divisor,
    input  logic [SW-1:0] side,
    output logic          out_valid,
    output logic [NW-1:0] quotient,
    output logic [SW-1:0] side_out
);

    logic          valid_reg [0:NW-1];
    logic [NW-1:0] num_reg   [0:NW-1];
    logic [DW-1:0] rem_reg   [0:NW-1];
    logic [DW-1:0] div_reg   [0:NW-1];
    logic [SW-1:0] side_reg  [0:NW-1];

    genvar g;
    generate
        for (g = 0; g < NW; g++)
        begin : g_stage
            logic          v_src;
            logic [NW-1:0] num_src;
            logic [DW-1:0] rem_src;
            logic [DW-1:0] div_src;
            logic [SW-1:0] side_src;
            logic [DW:0]   trial;
            logic          ge;
            logic [DW-1:0] rem_next;

            if (g == 0)
            begin : g_head
                assign v_src    = in_valid;
                assign num_src  = dividend;
                assign rem_src  = '0;
                assign div_src  = divisor;
                assign side_src = side;
            end
            else
            begin : g_body
                assign v_src    = valid_reg[g-1];
                assign num_src  = num_reg[g-1];
                assign rem_src  = rem_reg[g-1];
                assign div_src  = div_reg[g-1];
                assign side_src = side_reg[g-1];
            end

            assign trial    = {rem_src, num_src[NW-1]};
            assign ge       = trial >= {1'b0, div_src};
            assign rem_next = ge ? DW'(trial - {1'b0, div_src}) : trial[DW-1:0];

            always_ff @(posedge clk or negedge rst_n)
            begin
                if (!rst_n)
                begin
                    valid_reg[g] <= 1'b0;
                end
                else if (en)
                begin
                    valid_reg[g] <= v_src;
                end
            end

            always_ff @(posedge clk)
            begin
                if (en)
                begin
                    num_reg[g]  <= {num_src[NW-2:0], ge};
                    rem_reg[g]  <= rem_next;
                    div_reg[g]  <= div_src;
                    side_reg[g] <= side_src;
                end
            end
        end
    endgenerate

    assign out_valid = valid_reg[NW-1];
    assign quotient  = num_reg[NW-1];
    assign side_out  = side_reg[NW-1];

endmodule

// ===== rtl/core/ntc_tfd_checker.sv =====
// ----------------------------------------------------------------------------
// ntc_tfd_assert
// Port-level checks of the fan duty pipeline, bound to the top level.
// ----------------------------------------------------------------------------
module ntc_tfd_assert
    import ntc_tfd_pkg::*;
(
    input logic              clk,
    input logic              rst_n,
    input logic              adc_valid,
    input logic              adc_stall,
    input logic              duty_valid,
    input logic              duty_stall,
    input logic [DUTY_W-1:0] duty_count
);

    a_hold_result: assert property (@(posedge clk) disable iff (!rst_n)
        duty_valid && duty_stall |=> duty_valid && $stable(duty_count))
        else $error("stalled result changed or dropped");

    a_duty_range: assert property (@(posedge clk) disable iff (!rst_n)
        duty_valid |-> duty_count <= DUTY_W'(DUTY_MAX))
        else $error("duty above maximum");

    a_stall_link: assert property (@(posedge clk) disable iff (!rst_n)
        adc_valid |-> adc_stall == (duty_valid && duty_stall))
        else $error("input stall does not follow held output");

endmodule

bind ntc_temperature_fan_duty_top ntc_tfd_assert u_ntc_tfd_assert (
    .clk        (clk),
    .rst_n      (rst_n),
    .adc_valid  (adc_valid),
    .adc_stall  (adc_stall),
    .duty_valid (duty_valid),
    .duty_stall (duty_stall),
    .duty_count (duty_count)
);
